### src/pae_pkg.sv
// pae_pkg: shared widths, action codes, item types and saturation helpers
// for the pixel error-propagation arithmetic pipeline; no dependencies
`default_nettype none

package pae_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VW        = 32;
    localparam int DQW       = 16;
    localparam int ACTW      = 3;

    // product magnitudes stay below 2^62 + 1
    localparam int PW   = 2 * VW - 1;
    localparam int LOW  = PW / 2;
    localparam int HIW  = PW - LOW;
    localparam int HHW  = 2 * HIW;
    localparam int LLW  = 2 * LOW;
    localparam int XW   = 2 * PW;
    localparam int SXW  = 2 * VW;
    localparam int DW   = PW;
    localparam int QW   = VW + 1;
    localparam int ECW  = DW + QW;
    localparam int SCW  = VW + QW;

    localparam int SQ_STAGES  = PW;
    localparam int SSQ_STAGES = VW;
    localparam int DV_STAGES  = QW;

    localparam logic [ACTW-1:0] ACT_ADD  = 3'd0;
    localparam logic [ACTW-1:0] ACT_SUB  = 3'd1;
    localparam logic [ACTW-1:0] ACT_MUL  = 3'd2;
    localparam logic [ACTW-1:0] ACT_DIV  = 3'd3;
    localparam logic [ACTW-1:0] ACT_SUBC = 3'd4;
    localparam logic [ACTW-1:0] ACT_MULC = 3'd5;

    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    typedef struct packed {
        logic [ACTW-1:0]        action;
        logic signed [VW-1:0]   a_sci;
        logic signed [VW-1:0]   a_err;
        logic [DQW-1:0]         a_dq;
        logic signed [VW-1:0]   b_sci;
        logic signed [VW-1:0]   b_err;
        logic [DQW-1:0]         b_dq;
    } t_in_item;

    typedef struct packed {
        logic signed [VW-1:0]   sci_out;
        logic signed [VW-1:0]   err_out;
        logic [DQW-1:0]         dq_out;
        logic                   saturated;
    } t_out_item;

    typedef struct packed {
        logic           sat;
        logic [VW-1:0]  val;
    } t_clip;

    // item state through the square root stages
    typedef struct packed {
        logic [ACTW-1:0]    action;
        logic [DQW-1:0]     dq;
        logic [VW-1:0]      sci_pre;
        logic [VW-1:0]      err_pre;
        logic               sat_pre;
        logic               bzero;
        logic               neg;
        logic [VW-1:0]      mas;
        logic [VW-1:0]      mbs;
        logic [DW-1:0]      d;
        logic [XW-1:0]      rem;
        logic [PW-1:0]      res;
        logic [SXW-1:0]     srem;
        logic [VW-1:0]      sres;
    } t_sq;

    function automatic logic [VW-1:0] mag(input logic [VW-1:0] v);
        return v[VW-1] ? (~v + {{(VW-1){1'b0}}, 1'b1}) : v;
    endfunction

    function automatic t_clip clip_s(input logic [SXW:0] v);
        t_clip r;
        logic [SXW-VW+1:0] hi_bits;
        hi_bits = v[SXW:VW-1];
        if ((&hi_bits) || !(|hi_bits)) begin
            r.sat = 1'b0;
            r.val = v[VW-1:0];
        end else begin
            r.sat = 1'b1;
            r.val = v[SXW] ? VMIN : VMAX;
        end
        return r;
    endfunction

    function automatic t_clip clip_u(input logic [PW-1:0] v);
        t_clip r;
        if (|v[PW-1:VW-1]) begin
            r.sat = 1'b1;
            r.val = VMAX;
        end else begin
            r.sat = 1'b0;
            r.val = v[VW-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/pae_in_if.sv
// pae_in_if: input item channel, valid/ready with a t_in_item payload
// depends on pae_pkg
`default_nettype none

interface pae_in_if;
    import pae_pkg::*;

    logic       valid;
    logic       ready;
    t_in_item   item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

### src/pae_out_if.sv
// pae_out_if: result item channel, valid/ready with a t_out_item payload
// depends on pae_pkg
`default_nettype none

interface pae_out_if;
    import pae_pkg::*;

    logic       valid;
    logic       ready;
    t_out_item  item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

### src/pae_front.sv
// pae_front: four register stages of decode, sums, multiplies and squares
// that feed the square root stages; depends on pae_pkg
`default_nettype none

module pae_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  pae_pkg::t_in_item       i_item,
    input  logic [pae_pkg::VW-1:0]  i_const,
    output logic                    o_valid,
    output pae_pkg::t_sq            o_data
);
    import pae_pkg::*;

    typedef struct packed {
        logic [ACTW-1:0]    action;
        logic [DQW-1:0]     dq;
        logic [VW-1:0]      sci_pre;
        logic [VW-1:0]      err_pre;
        logic               sat_pre;
        logic               bzero;
        logic               neg;
        logic [VW-1:0]      as;
        logic [VW-1:0]      ae;
        logic [VW-1:0]      bs;
        logic [VW-1:0]      mas;
        logic [VW-1:0]      mae;
        logic [VW-1:0]      mbs;
        logic [VW-1:0]      mbe;
    } t_f1;

    typedef struct packed {
        logic [ACTW-1:0]    action;
        logic [DQW-1:0]     dq;
        logic [VW-1:0]      sci_pre;
        logic [VW-1:0]      err_pre;
        logic               sat_pre;
        logic               bzero;
        logic               neg;
        logic [VW-1:0]      mas;
        logic [VW-1:0]      mbs;
        logic [PW-1:0]      pa;
        logic [PW-1:0]      pb;
        logic [SXW-1:0]     ps;
        logic [SXW-1:0]     pe;
        logic [DW-1:0]      d;
        logic [PW-1:0]      sa;
        logic [PW-1:0]      sb;
    } t_f2;

    typedef struct packed {
        logic [ACTW-1:0]    action;
        logic [DQW-1:0]     dq;
        logic [VW-1:0]      sci_pre;
        logic [VW-1:0]      err_pre;
        logic               sat_pre;
        logic               bzero;
        logic               neg;
        logic [VW-1:0]      mas;
        logic [VW-1:0]      mbs;
        logic [DW-1:0]      d;
        logic [HHW-1:0]     hh_a;
        logic [PW-1:0]      hl_a;
        logic [LLW-1:0]     ll_a;
        logic [HHW-1:0]     hh_b;
        logic [PW-1:0]      hl_b;
        logic [LLW-1:0]     ll_b;
        logic [SXW-1:0]     x2;
    } t_f3;

    t_f1 r_f1, n_f1;
    t_f2 r_f2, n_f2;
    t_f3 r_f3, n_f3;
    t_sq r_f4, n_f4;
    logic r_f1_v, r_f2_v, r_f3_v, r_f4_v;

    // stage 1: magnitudes, sums and pass-through values
    logic [SXW:0]   w_a_ext, w_b_ext, w_c_ext, w_sum;
    t_clip          w_sum_clip;

    assign w_a_ext = {{(SXW+1-VW){i_item.a_sci[VW-1]}}, i_item.a_sci};
    assign w_b_ext = {{(SXW+1-VW){i_item.b_sci[VW-1]}}, i_item.b_sci};
    assign w_c_ext = {{(SXW+1-VW){i_const[VW-1]}}, i_const};
    assign w_sum   = (i_item.action == ACT_ADD) ? (w_a_ext + w_b_ext) :
                     (i_item.action == ACT_SUB) ? (w_a_ext - w_b_ext) :
                                                  (w_a_ext - w_c_ext);
    assign w_sum_clip = clip_s(w_sum);

    always_comb begin
        n_f1.action  = i_item.action;
        n_f1.dq      = (i_item.action <= ACT_DIV) ? (i_item.a_dq | i_item.b_dq) : i_item.a_dq;
        n_f1.as      = i_item.a_sci;
        n_f1.ae      = i_item.a_err;
        n_f1.bs      = i_item.b_sci;
        n_f1.mas     = mag(i_item.a_sci);
        n_f1.mae     = mag(i_item.a_err);
        n_f1.mbs     = mag(i_item.b_sci);
        n_f1.mbe     = mag(i_item.b_err);
        n_f1.bzero   = (i_item.b_sci == '0);
        n_f1.neg     = i_item.a_sci[VW-1] ^ i_item.b_sci[VW-1];
        n_f1.err_pre = i_item.a_err;
        n_f1.sci_pre = i_item.a_sci;
        n_f1.sat_pre = 1'b0;
        if (i_item.action == ACT_ADD || i_item.action == ACT_SUB ||
            i_item.action == ACT_SUBC) begin
            n_f1.sci_pre = w_sum_clip.val;
            n_f1.sat_pre = w_sum_clip.sat;
        end
    end

    // stage 2: products
    logic [SXW-1:0]         w_pa, w_pb, w_d, w_sa, w_sb;
    logic [VW-1:0]          w_mul_b;
    logic signed [SXW-1:0]  w_ps, w_pe;

    assign w_pa    = r_f1.mas * r_f1.mbe;
    assign w_pb    = r_f1.mbs * r_f1.mae;
    assign w_d     = r_f1.mbs * r_f1.mbs;
    assign w_sa    = r_f1.mae * r_f1.mae;
    assign w_sb    = r_f1.mbe * r_f1.mbe;
    assign w_mul_b = (r_f1.action == ACT_MULC) ? i_const : r_f1.bs;
    assign w_ps    = $signed(r_f1.as) * $signed(w_mul_b);
    assign w_pe    = $signed(r_f1.ae) * $signed(i_const);

    always_comb begin
        n_f2.action  = r_f1.action;
        n_f2.dq      = r_f1.dq;
        n_f2.sci_pre = r_f1.sci_pre;
        n_f2.err_pre = r_f1.err_pre;
        n_f2.sat_pre = r_f1.sat_pre;
        n_f2.bzero   = r_f1.bzero;
        n_f2.neg     = r_f1.neg;
        n_f2.mas     = r_f1.mas;
        n_f2.mbs     = r_f1.mbs;
        n_f2.pa      = w_pa[PW-1:0];
        n_f2.pb      = w_pb[PW-1:0];
        n_f2.ps      = w_ps;
        n_f2.pe      = w_pe;
        n_f2.d       = w_d[DW-1:0];
        n_f2.sa      = w_sa[PW-1:0];
        n_f2.sb      = w_sb[PW-1:0];
    end

    // stage 3: rescale and clip products, partial squares
    logic signed [SXW-1:0]  w_ps_sh, w_pe_sh;
    t_clip                  w_ps_clip, w_pe_clip;

    assign w_ps_sh   = $signed(r_f2.ps) >>> FRAC_BITS;
    assign w_pe_sh   = $signed(r_f2.pe) >>> FRAC_BITS;
    assign w_ps_clip = clip_s({w_ps_sh[SXW-1], w_ps_sh});
    assign w_pe_clip = clip_s({w_pe_sh[SXW-1], w_pe_sh});

    always_comb begin
        n_f3.action  = r_f2.action;
        n_f3.dq      = r_f2.dq;
        n_f3.sci_pre = r_f2.sci_pre;
        n_f3.err_pre = r_f2.err_pre;
        n_f3.sat_pre = r_f2.sat_pre;
        n_f3.bzero   = r_f2.bzero;
        n_f3.neg     = r_f2.neg;
        n_f3.mas     = r_f2.mas;
        n_f3.mbs     = r_f2.mbs;
        n_f3.d       = r_f2.d;
        n_f3.hh_a    = r_f2.pa[PW-1:LOW] * r_f2.pa[PW-1:LOW];
        n_f3.hl_a    = r_f2.pa[PW-1:LOW] * r_f2.pa[LOW-1:0];
        n_f3.ll_a    = r_f2.pa[LOW-1:0] * r_f2.pa[LOW-1:0];
        n_f3.hh_b    = r_f2.pb[PW-1:LOW] * r_f2.pb[PW-1:LOW];
        n_f3.hl_b    = r_f2.pb[PW-1:LOW] * r_f2.pb[LOW-1:0];
        n_f3.ll_b    = r_f2.pb[LOW-1:0] * r_f2.pb[LOW-1:0];
        n_f3.x2      = {1'b0, r_f2.sa} + {1'b0, r_f2.sb};
        if (r_f2.action == ACT_MUL) begin
            n_f3.sci_pre = w_ps_clip.val;
            n_f3.sat_pre = w_ps_clip.sat;
        end else if (r_f2.action == ACT_MULC) begin
            n_f3.sci_pre = w_ps_clip.val;
            n_f3.err_pre = w_pe_clip.val;
            n_f3.sat_pre = w_ps_clip.sat | w_pe_clip.sat;
        end
    end

    // stage 4: sum of squares
    logic [XW-1:0] w_hh, w_hl, w_ll;

    assign w_hh = {{(XW-HHW){1'b0}}, r_f3.hh_a} + {{(XW-HHW){1'b0}}, r_f3.hh_b};
    assign w_hl = {{(XW-PW){1'b0}}, r_f3.hl_a} + {{(XW-PW){1'b0}}, r_f3.hl_b};
    assign w_ll = {{(XW-LLW){1'b0}}, r_f3.ll_a} + {{(XW-LLW){1'b0}}, r_f3.ll_b};

    always_comb begin
        n_f4.action  = r_f3.action;
        n_f4.dq      = r_f3.dq;
        n_f4.sci_pre = r_f3.sci_pre;
        n_f4.err_pre = r_f3.err_pre;
        n_f4.sat_pre = r_f3.sat_pre;
        n_f4.bzero   = r_f3.bzero;
        n_f4.neg     = r_f3.neg;
        n_f4.mas     = r_f3.mas;
        n_f4.mbs     = r_f3.mbs;
        n_f4.d       = r_f3.d;
        n_f4.rem     = (w_hh << (2 * LOW)) + (w_hl << (LOW + 1)) + w_ll;
        n_f4.res     = '0;
        n_f4.srem    = r_f3.x2;
        n_f4.sres    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
            r_f4_v <= 1'b0;
        end else if (i_en) begin
            r_f1_v <= i_valid;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
            r_f4_v <= r_f3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1 <= n_f1;
            r_f2 <= n_f2;
            r_f3 <= n_f3;
            r_f4 <= n_f4;
        end
    end

    assign o_valid = r_f4_v;
    assign o_data  = r_f4;

endmodule

`default_nettype wire

### src/pixel_arith_error_propagation.sv
// pixel_arith_error_propagation: top level, square root and divider stages,
// result stage; depends on pae_pkg, pae_in_if, pae_out_if, pae_front
//
//  channel   | dir | handshake         | payload
//  i_in      | in  | valid/ready       | t_in_item: action, a/b sci, err, dq
//  o_out     | out | valid/ready       | t_out_item: sci, err, dq, saturated
//  i_cfg_*   | in  | write enable only | constant_value
//
// one item per cycle while the output register is empty or taken
// 4 front stages, 63 square root stages (one root bit each), 1 setup stage,
// 33 divider stages (one quotient bit each), 1 output register
// all stages advance together whenever the output register is empty or taken
// synchronous reset clears the valid bits and the constant register
`default_nettype none

module pixel_arith_error_propagation (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [pae_pkg::VW-1:0]  i_cfg_wdata,
    pae_in_if.sink                  i_in,
    pae_out_if.source               o_out
);
    import pae_pkg::*;

    typedef struct packed {
        logic [ACTW-1:0]    action;
        logic [DQW-1:0]     dq;
        logic [VW-1:0]      sci_pre;
        logic [VW-1:0]      err_pre;
        logic               sat_pre;
        logic               bzero;
        logic               neg;
        logic               over_e;
        logic               over_s;
        logic [DW-1:0]      d;
        logic [VW-1:0]      mbs;
        logic [ECW-1:0]     er;
        logic [QW-1:0]      eq;
        logic [SCW-1:0]     sr;
        logic [QW-1:0]      sq;
    } t_dv;

    localparam logic [XW-1:0]  ONE_X = {{(XW-1){1'b0}}, 1'b1};
    localparam logic [PW-1:0]  ONE_P = {{(PW-1){1'b0}}, 1'b1};
    localparam logic [SXW-1:0] ONE_S = {{(SXW-1){1'b0}}, 1'b1};
    localparam logic [VW-1:0]  ONE_V = {{(VW-1){1'b0}}, 1'b1};
    localparam logic [QW-1:0]  ONE_Q = {{(QW-1){1'b0}}, 1'b1};
    localparam logic [QW-1:0]  QMAX  = {2'b00, {(VW-1){1'b1}}};
    localparam logic [QW-1:0]  QMINM = {2'b01, {(VW-1){1'b0}}};

    logic           w_adv;
    logic [VW-1:0]  r_const;
    logic           w_front_v;
    t_sq            w_front;

    assign w_adv      = !o_out.valid || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_const <= '0;
        end else if (i_cfg_we) begin
            r_const <= i_cfg_wdata;
        end
    end

    pae_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_in.valid),
        .i_item  (i_in.item),
        .i_const (r_const),
        .o_valid (w_front_v),
        .o_data  (w_front)
    );

    // square root stages: main root bit per stage, small root in the first ones
    t_sq                    w_sq_in [SQ_STAGES];
    t_sq                    n_sq [SQ_STAGES];
    t_sq                    r_sq [SQ_STAGES];
    logic [SQ_STAGES-1:0]   w_sq_vin;
    logic [SQ_STAGES-1:0]   r_sq_v;
    logic [SXW-1:0]         w_srem [SQ_STAGES];
    logic [VW-1:0]          w_sres [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
        localparam int BIT = PW - 1 - k;
        logic [XW-1:0] w_term;

        if (k == 0) begin : g_first
            assign w_sq_in[k]  = w_front;
            assign w_sq_vin[k] = w_front_v;
        end else begin : g_next
            assign w_sq_in[k]  = r_sq[k-1];
            assign w_sq_vin[k] = r_sq_v[k-1];
        end

        if (k < SSQ_STAGES) begin : g_small
            localparam int SBIT = VW - 1 - k;
            logic [SXW-1:0] w_sterm;
            assign w_sterm = ({{(SXW-VW){1'b0}}, w_sq_in[k].sres} << (SBIT + 1)) |
                             (ONE_S << (2 * SBIT));
            assign w_srem[k] = (w_sq_in[k].srem >= w_sterm) ?
                               (w_sq_in[k].srem - w_sterm) : w_sq_in[k].srem;
            assign w_sres[k] = (w_sq_in[k].srem >= w_sterm) ?
                               (w_sq_in[k].sres | (ONE_V << SBIT)) : w_sq_in[k].sres;
        end else begin : g_hold
            assign w_srem[k] = w_sq_in[k].srem;
            assign w_sres[k] = w_sq_in[k].sres;
        end

        assign w_term = ({{(XW-PW){1'b0}}, w_sq_in[k].res} << (BIT + 1)) |
                        (ONE_X << (2 * BIT));

        always_comb begin
            n_sq[k]      = w_sq_in[k];
            n_sq[k].srem = w_srem[k];
            n_sq[k].sres = w_sres[k];
            if (w_sq_in[k].rem >= w_term) begin
                n_sq[k].rem = w_sq_in[k].rem - w_term;
                n_sq[k].res = w_sq_in[k].res | (ONE_P << BIT);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (w_adv) begin
                r_sq_v[k] <= w_sq_vin[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq[k] <= n_sq[k];
            end
        end
    end

    // setup stage: error selection for add, subtract, multiply; divider start
    t_sq            w_root;
    logic [PW-1:0]  w_e_sh, w_e_mul;
    t_clip          w_e_clip, w_s_clip;
    t_dv            n_dp, r_dp;
    logic           r_dp_v;

    assign w_root   = r_sq[SQ_STAGES-1];
    assign w_e_sh   = w_root.res >> FRAC_BITS;
    assign w_e_mul  = (w_e_sh == '0) ? {{(PW-VW){1'b0}}, w_root.sres} : w_e_sh;
    assign w_e_clip = clip_u(w_e_mul);
    assign w_s_clip = clip_u({{(PW-VW){1'b0}}, w_root.sres});

    always_comb begin
        n_dp.action  = w_root.action;
        n_dp.dq      = w_root.dq;
        n_dp.sci_pre = w_root.sci_pre;
        n_dp.err_pre = w_root.err_pre;
        n_dp.sat_pre = w_root.sat_pre;
        n_dp.bzero   = w_root.bzero;
        n_dp.neg     = w_root.neg;
        n_dp.d       = w_root.d;
        n_dp.mbs     = w_root.mbs;
        n_dp.over_e  = {{(ECW-PW){1'b0}}, w_root.res} >=
                       ({{(ECW-DW){1'b0}}, w_root.d} << (VW - 1 - FRAC_BITS));
        n_dp.er      = {{(ECW-PW){1'b0}}, w_root.res} << FRAC_BITS;
        n_dp.over_s  = ({{(SCW-VW){1'b0}}, w_root.mas} << FRAC_BITS) >=
                       ({{(SCW-VW){1'b0}}, w_root.mbs} << QW);
        n_dp.sr      = {{(SCW-VW){1'b0}}, w_root.mas} << FRAC_BITS;
        n_dp.eq      = '0;
        n_dp.sq      = '0;
        if (w_root.action == ACT_MUL) begin
            n_dp.err_pre = w_e_clip.val;
            n_dp.sat_pre = w_root.sat_pre | w_e_clip.sat;
        end else if (w_root.action == ACT_ADD || w_root.action == ACT_SUB) begin
            n_dp.err_pre = w_s_clip.val;
            n_dp.sat_pre = w_root.sat_pre | w_s_clip.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp_v <= 1'b0;
        end else if (w_adv) begin
            r_dp_v <= r_sq_v[SQ_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dp <= n_dp;
        end
    end

    // divider stages: one bit of each quotient per stage
    t_dv                    w_dv_in [DV_STAGES];
    t_dv                    n_dv [DV_STAGES];
    t_dv                    r_dv [DV_STAGES];
    logic [DV_STAGES-1:0]   w_dv_vin;
    logic [DV_STAGES-1:0]   r_dv_v;

    for (genvar k = 0; k < DV_STAGES; k++) begin : g_dv
        localparam int BIT = QW - 1 - k;
        logic [ECW-1:0] w_td;
        logic [SCW-1:0] w_ts;

        if (k == 0) begin : g_first
            assign w_dv_in[k]  = r_dp;
            assign w_dv_vin[k] = r_dp_v;
        end else begin : g_next
            assign w_dv_in[k]  = r_dv[k-1];
            assign w_dv_vin[k] = r_dv_v[k-1];
        end

        assign w_td = {{(ECW-DW){1'b0}}, w_dv_in[k].d} << BIT;
        assign w_ts = {{(SCW-VW){1'b0}}, w_dv_in[k].mbs} << BIT;

        always_comb begin
            n_dv[k] = w_dv_in[k];
            if (w_dv_in[k].er >= w_td) begin
                n_dv[k].er = w_dv_in[k].er - w_td;
                n_dv[k].eq = w_dv_in[k].eq | (ONE_Q << BIT);
            end
            if (w_dv_in[k].sr >= w_ts) begin
                n_dv[k].sr = w_dv_in[k].sr - w_ts;
                n_dv[k].sq = w_dv_in[k].sq | (ONE_Q << BIT);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (w_adv) begin
                r_dv_v[k] <= w_dv_vin[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    // result stage
    t_dv        w_fin;
    logic [VW-1:0] w_sq_neg;
    t_out_item  n_out, r_out;
    logic       r_out_v;

    assign w_fin    = r_dv[DV_STAGES-1];
    assign w_sq_neg = ~w_fin.sq[VW-1:0] + ONE_V;

    always_comb begin
        n_out.sci_out   = w_fin.sci_pre;
        n_out.err_out   = w_fin.err_pre;
        n_out.dq_out    = w_fin.dq;
        n_out.saturated = w_fin.sat_pre;
        if (w_fin.action == ACT_DIV) begin
            if (w_fin.bzero) begin
                n_out.sci_out   = '0;
                n_out.err_out   = VMAX;
                n_out.saturated = 1'b1;
            end else begin
                n_out.saturated = 1'b0;
                if (w_fin.over_s) begin
                    n_out.sci_out   = w_fin.neg ? VMIN : VMAX;
                    n_out.saturated = 1'b1;
                end else if (w_fin.neg) begin
                    if (w_fin.sq > QMINM) begin
                        n_out.sci_out   = VMIN;
                        n_out.saturated = 1'b1;
                    end else begin
                        n_out.sci_out = w_sq_neg;
                    end
                end else if (w_fin.sq > QMAX) begin
                    n_out.sci_out   = VMAX;
                    n_out.saturated = 1'b1;
                end else begin
                    n_out.sci_out = w_fin.sq[VW-1:0];
                end
                if (w_fin.over_e) begin
                    n_out.err_out   = VMAX;
                    n_out.saturated = 1'b1;
                end else begin
                    n_out.err_out = w_fin.eq[VW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= r_dv_v[DV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.item  = r_out;

endmodule

`default_nettype wire

### src/pae_checker.sv
// pae_checker: port-level checks on the pixel arithmetic pipeline, bound
// to the top level; depends on pae_pkg
`default_nettype none

module pae_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_ready,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  pae_pkg::t_out_item  i_out_item
);
    import pae_pkg::*;

    // pipeline takes an item whenever no result is waiting
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");

    // nothing comes out right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_item))
        else $error("result item changed while stalled");

endmodule

bind pixel_arith_error_propagation pae_checker u_pae_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.item)
);

`default_nettype wire
